// File: hw/rtl/sobx_pkg.sv
`timescale 1ns / 1ps

package sobx_pkg;

    localparam int PIXEL_BITS  = 8;
    localparam int CFG_BITS    = 10;
    localparam int RESULT_BITS = 11;
    localparam int IN_TDATA_BITS  = 8;
    localparam int OUT_TDATA_BITS = 16;
    localparam int MIN_DIM     = 3;

    typedef enum logic [0:0] {
        REG_ROW_PIXELS = 1'b0,
        REG_FRAME_ROWS = 1'b1
    } t_reg_index;

    typedef logic [PIXEL_BITS-1:0]         t_pixel;
    typedef logic signed [RESULT_BITS-1:0] t_result;

    typedef struct packed {
        logic    last;
        t_result value;
    } t_out_beat;

endpackage

// File: hw/rtl/sobel_x_3x3_convolution.sv
`timescale 1ns / 1ps

// Streaming Sobel-X 3x3 filter. Pixels enter in raster order, one beat per clock;
// one result beat leaves for every interior pixel (x,y) after pixel (x+1,y+1) is
// taken: its line-buffer read is registered, then its kernel sum enters the output queue.
// Both line buffers share one memory of MAX_WIDTH entries, read at the column of
// the incoming pixel and written back in the next clock. Sustained rate is one pixel
// per clock; the input stalls when the queued result beats plus the pixel in the
// kernel stage reach four, the depth of the output queue.
// The row width and frame height (register indexes 0 and 1) are clamped to
// 3..MAX_WIDTH and 3..MAX_HEIGHT and should be written only while the block is idle.
// tlast marks the last interior result of each frame.
module sobel_x_3x3_convolution #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_index,
    input  logic [sobx_pkg::CFG_BITS-1:0]       i_cfg_data,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [sobx_pkg::IN_TDATA_BITS-1:0]  i_s_axis_tdata,  // [7:0] pixel_value
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [sobx_pkg::OUT_TDATA_BITS-1:0] o_m_axis_tdata,  // [10:0] filtered_value
    output logic                                o_m_axis_tlast   // frame_last
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = CW + 1;
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int HW = RW + 1;
    localparam int PB = sobx_pkg::PIXEL_BITS;
    localparam int SB = PB + 2;
    localparam int RB = sobx_pkg::RESULT_BITS;
    localparam int QDEPTH = 4;
    localparam int QW = $clog2(QDEPTH);

    // configuration
    logic [sobx_pkg::CFG_BITS-1:0] r_width_cfg;
    logic [sobx_pkg::CFG_BITS-1:0] r_height_cfg;
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_cfg  <= sobx_pkg::CFG_BITS'(512);
            r_height_cfg <= sobx_pkg::CFG_BITS'(512);
        end else if (i_cfg_we) begin
            unique case (sobx_pkg::t_reg_index'(i_cfg_index))
                sobx_pkg::REG_ROW_PIXELS: r_width_cfg  <= i_cfg_data;
                sobx_pkg::REG_FRAME_ROWS: r_height_cfg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (int'(r_width_cfg) < sobx_pkg::MIN_DIM) begin
            w_eff = WW'(sobx_pkg::MIN_DIM);
        end else if (int'(r_width_cfg) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_width_cfg);
        end
        if (int'(r_height_cfg) < sobx_pkg::MIN_DIM) begin
            h_eff = HW'(sobx_pkg::MIN_DIM);
        end else if (int'(r_height_cfg) > MAX_HEIGHT) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(r_height_cfg);
        end
    end

    // counters and accept stage
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [CW-1:0] n_col;
    logic [RW-1:0] n_row;
    logic [CW-1:0] cur_col;
    logic [RW-1:0] cur_row;
    logic [HW-1:0] row_step;
    logic [WW-1:0] col_inc;
    logic [HW-1:0] row_inc;
    logic          cur_prod;
    logic          cur_last;
    logic          accept;

    always_comb begin
        row_step = HW'(r_row);
        if (WW'(r_col) >= w_eff) begin
            cur_col  = '0;
            row_step = HW'(r_row) + HW'(1);
        end else begin
            cur_col = r_col;
        end
        cur_row = (row_step >= h_eff) ? '0 : row_step[RW-1:0];

        col_inc = WW'(cur_col) + WW'(1);
        row_inc = HW'(cur_row) + HW'(1);
        if (col_inc >= w_eff) begin
            n_col = '0;
            n_row = (row_inc >= h_eff) ? '0 : row_inc[RW-1:0];
        end else begin
            n_col = col_inc[CW-1:0];
            n_row = cur_row;
        end

        cur_prod = (cur_col >= CW'(2)) && (cur_row >= RW'(2));
        cur_last = (WW'(cur_col) == w_eff - WW'(1)) && (HW'(cur_row) == h_eff - HW'(1));
    end

    // line buffers: {older, previous} per column
    logic [2*PB-1:0] r_lbuf [MAX_WIDTH];
    logic [2*PB-1:0] r_lbuf_rd;

    logic          r_s1_valid;
    logic          r_s1_prod;
    logic          r_s1_last;
    logic [CW-1:0] r_s1_col;
    logic [PB-1:0] r_s1_pix;

    logic [QW:0]   r_qcnt;

    assign o_s_axis_tready = (r_qcnt + (QW+1)'(r_s1_valid)) < (QW+1)'(QDEPTH);
    assign accept = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_lbuf_rd <= r_lbuf[cur_col];
        end
        if (r_s1_valid) begin
            r_lbuf[r_s1_col] <= {r_lbuf_rd[PB-1:0], r_s1_pix};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_prod <= cur_prod;
            r_s1_last <= cur_last;
            r_s1_col  <= cur_col;
            r_s1_pix  <= i_s_axis_tdata[PB-1:0];
        end
    end

    // window and kernel sum
    logic [PB-1:0] r_win [6];
    logic [PB-1:0] s1_top;
    logic [PB-1:0] s1_mid;
    logic [SB-1:0] sum_left;
    logic [SB-1:0] sum_right;
    logic signed [RB-1:0] s1_result;

    assign s1_top = r_lbuf_rd[2*PB-1:PB];
    assign s1_mid = r_lbuf_rd[PB-1:0];

    always_comb begin
        sum_left  = SB'(r_win[0]) + {1'b0, r_win[1], 1'b0} + SB'(r_win[2]);
        sum_right = SB'(s1_top) + {1'b0, s1_mid, 1'b0} + SB'(r_s1_pix);
        s1_result = $signed(RB'(sum_right)) - $signed(RB'(sum_left));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (r_s1_valid) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= s1_top;
            r_win[4] <= s1_mid;
            r_win[5] <= r_s1_pix;
        end
    end

    // output queue
    sobx_pkg::t_out_beat r_q [QDEPTH];
    logic [QW-1:0] r_qwp;
    logic [QW-1:0] r_qrp;
    logic          q_push;
    logic          q_pop;

    assign q_push = r_s1_valid && r_s1_prod;
    assign q_pop  = o_m_axis_tvalid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (q_push) begin
            r_q[r_qwp] <= '{last: r_s1_last, value: s1_result};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qwp  <= '0;
            r_qrp  <= '0;
            r_qcnt <= '0;
        end else begin
            if (q_push) begin
                r_qwp <= r_qwp + QW'(1);
            end
            if (q_pop) begin
                r_qrp <= r_qrp + QW'(1);
            end
            r_qcnt <= r_qcnt + (QW+1)'(q_push) - (QW+1)'(q_pop);
        end
    end

    assign o_m_axis_tvalid = (r_qcnt != '0);
    assign o_m_axis_tdata  = {{(sobx_pkg::OUT_TDATA_BITS-RB){1'b0}}, r_q[r_qrp].value};
    assign o_m_axis_tlast  = r_q[r_qrp].last;

endmodule

// File: dv/sobel_x_3x3_convolution_test.sv
`timescale 1ns / 1ps

module sobel_x_3x3_convolution_test;

    localparam int MAX_W        = 512;
    localparam int MAX_H        = 512;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int RANDOM_BEATS = 36;
    localparam int FILL_W       = 24;
    localparam int TALL_H       = 16;

    logic                                i_clk           = 1'b0;
    logic                                i_rst_n         = 1'b0;
    logic                                i_cfg_we        = 1'b0;
    logic                                i_cfg_index     = sobx_pkg::REG_ROW_PIXELS;
    logic [sobx_pkg::CFG_BITS-1:0]       i_cfg_data      = '0;
    logic                                i_s_axis_tvalid = 1'b0;
    logic                                o_s_axis_tready;
    logic [sobx_pkg::IN_TDATA_BITS-1:0]  i_s_axis_tdata  = '0;
    logic                                o_m_axis_tvalid;
    logic                                i_m_axis_tready = 1'b0;
    logic [sobx_pkg::OUT_TDATA_BITS-1:0] o_m_axis_tdata;
    logic                                o_m_axis_tlast;

    sobel_x_3x3_convolution #(
        .MAX_WIDTH (MAX_W),
        .MAX_HEIGHT(MAX_H)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tlast (o_m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    sobx_pkg::t_pixel              line_prev  [MAX_W];
    sobx_pkg::t_pixel              line_older [MAX_W];
    sobx_pkg::t_pixel              win_col    [6];
    int unsigned                   col_cnt;
    int unsigned                   row_cnt;
    logic [sobx_pkg::CFG_BITS-1:0] width_reg  = sobx_pkg::CFG_BITS'(512);
    logic [sobx_pkg::CFG_BITS-1:0] height_reg = sobx_pkg::CFG_BITS'(512);

    sobx_pkg::t_out_beat expected_gradients[$];
    int unsigned mismatches    = 0;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int unsigned stall_request = 0;
    int unsigned stall_left    = 0;

    function automatic int unsigned clamp_dim(logic [sobx_pkg::CFG_BITS-1:0] v,
                                              int unsigned maxv);
        if (v < sobx_pkg::MIN_DIM) return sobx_pkg::MIN_DIM;
        if (v > maxv) return maxv;
        return 32'(v);
    endfunction

    task automatic predict_sobel_x(input sobx_pkg::t_pixel px);
        int unsigned         w;
        int unsigned         h;
        int unsigned         col;
        int unsigned         row;
        sobx_pkg::t_pixel    top;
        sobx_pkg::t_pixel    mid;
        int                  left;
        int                  right;
        sobx_pkg::t_out_beat beat;
        w = clamp_dim(width_reg, MAX_W);
        h = clamp_dim(height_reg, MAX_H);
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt = row_cnt + 1;
        end
        if (row_cnt >= h) row_cnt = 0;
        col = col_cnt;
        row = row_cnt;
        top = line_older[col];
        mid = line_prev[col];
        if (col >= 2 && row >= 2) begin
            left  = int'(win_col[0]) + 2 * int'(win_col[1]) + int'(win_col[2]);
            right = int'(top) + 2 * int'(mid) + int'(px);
            beat.value = sobx_pkg::t_result'(right - left);
            beat.last  = (col == w - 1) && (row == h - 1);
            expected_gradients.push_back(beat);
        end
        win_col[0] = win_col[3];
        win_col[1] = win_col[4];
        win_col[2] = win_col[5];
        win_col[3] = top;
        win_col[4] = mid;
        win_col[5] = px;
        line_older[col] = mid;
        line_prev[col]  = px;
        col_cnt = col + 1;
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt = row + 1;
            if (row_cnt >= h) row_cnt = 0;
        end
    endtask

    task automatic send_pixel(input sobx_pkg::t_pixel px);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= px;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict_sobel_x(px);
    endtask

    // sender goes quiet until every result is back or the drain limit runs out, then the pipe settles
    task automatic wait_idle();
        int unsigned waited;
        waited = 0;
        i_s_axis_tvalid <= 1'b0;
        while (expected_gradients.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_dims(input int unsigned w, input int unsigned h);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= sobx_pkg::REG_ROW_PIXELS;
        i_cfg_data  <= sobx_pkg::CFG_BITS'(w);
        @(posedge i_clk);
        width_reg    = sobx_pkg::CFG_BITS'(w);
        i_cfg_index <= sobx_pkg::REG_FRAME_ROWS;
        i_cfg_data  <= sobx_pkg::CFG_BITS'(h);
        @(posedge i_clk);
        height_reg = sobx_pkg::CFG_BITS'(h);
        i_cfg_we  <= 1'b0;
    endtask

    function automatic sobx_pkg::t_pixel pick_pixel();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return sobx_pkg::t_pixel'($urandom_range(255));
        endcase
    endfunction

    // widths stay within the line-buffer entries already filled
    function automatic int unsigned pick_dim(int unsigned hi_small, bit allow_big);
        case ($urandom_range(11))
            0:       return $urandom_range(2);
            1:       return allow_big ? $urandom_range(1023, 513) : hi_small;
            default: return $urandom_range(hi_small, sobx_pkg::MIN_DIM);
        endcase
    endfunction

    // beat receiver: random stalls plus an optional long hold-off
    always @(posedge i_clk) begin
        if (stall_request != 0) begin
            stall_left    = stall_request;
            stall_request = 0;
        end
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        sobx_pkg::t_out_beat want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_gradients.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: value %0d last %0b",
                             $signed(o_m_axis_tdata[sobx_pkg::RESULT_BITS-1:0]),
                             o_m_axis_tlast);
            end else begin
                want = expected_gradients.pop_front();
                if (o_m_axis_tdata[sobx_pkg::RESULT_BITS-1:0] !== want.value ||
                    o_m_axis_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"beat mismatch: expected value %0d last %0b, ",
                                  "got value %0d last %0b"},
                                 want.value, want.last,
                                 $signed(o_m_axis_tdata[sobx_pkg::RESULT_BITS-1:0]),
                                 o_m_axis_tlast);
                end
            end
        end
    end

    // 3x3 frames (dims written below the minimum), full-scale positive and negative edges
    task automatic test_extremes();
        sobx_pkg::t_pixel frame_cols [3];
        set_dims(0, 2);
        for (int f = 0; f < 2; f++) begin
            frame_cols[0] = (f == 0) ? sobx_pkg::t_pixel'(0) : sobx_pkg::t_pixel'(255);
            frame_cols[1] = sobx_pkg::t_pixel'(77 + f * 51);
            frame_cols[2] = (f == 0) ? sobx_pkg::t_pixel'(255) : sobx_pkg::t_pixel'(0);
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++) send_pixel(frame_cols[c]);
        end
        wait_idle();
    endtask

    // one full wide frame, fills the line-buffer entries that later widening reaches
    task automatic test_wide_frame();
        set_dims(FILL_W, 2);
        for (int i = 0; i < FILL_W * 3; i++) send_pixel(pick_pixel());
        wait_idle();
    endtask

    task automatic test_tall_frame();
        set_dims(3, TALL_H);
        for (int i = 0; i < TALL_H * 3; i++) send_pixel(pick_pixel());
        wait_idle();
    endtask

    // shrink width past the column, widen mid-row, shrink height past the row
    task automatic test_resize_midframe();
        set_dims(10, 8);
        for (int i = 0; i < 25; i++) send_pixel(pick_pixel());
        wait_idle();
        set_dims(4, 8);
        for (int i = 0; i < 10; i++) send_pixel(pick_pixel());
        wait_idle();
        set_dims(20, 8);
        for (int i = 0; i < 30; i++) send_pixel(pick_pixel());
        wait_idle();
        set_dims(20, 3);
        for (int i = 0; i < 40; i++) send_pixel(pick_pixel());
        wait_idle();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        set_dims(5, 4);
        stall_request = 200;
        for (int i = 0; i < 60; i++) send_pixel(pick_pixel());
        wait_idle();
    endtask

    task automatic test_random_stream(input int unsigned idle_pct, input int unsigned hold_pct);
        send_idle_pct = idle_pct;
        stall_pct     = hold_pct;
        set_dims(pick_dim(12, 1'b0), pick_dim(10, 1'b1));
        for (int i = 0; i < RANDOM_BEATS; i++) begin
            send_pixel(pick_pixel());
            if ($urandom_range(39) == 0) begin
                wait_idle();
                if ($urandom_range(1) == 1) set_dims(pick_dim(16, 1'b0), pick_dim(10, 1'b1));
            end
        end
        wait_idle();
    endtask

    initial begin
        for (int i = 0; i < MAX_W; i++) begin
            line_prev[i]  = '0;
            line_older[i] = '0;
        end
        for (int i = 0; i < 6; i++) win_col[i] = '0;
        col_cnt = 0;
        row_cnt = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_extremes();
        test_wide_frame();
        test_tall_frame();
        test_resize_midframe();
        test_backpressure();
        test_random_stream(0, 0);
        test_random_stream(76, 0);
        test_random_stream(0, 76);
        test_random_stream(16, 16);

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (expected_gradients.size() != 0) begin
            mismatches++;
            $display("%0d expected beats never arrived", expected_gradients.size());
        end
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/sobx_pkg.sv
hw/rtl/sobel_x_3x3_convolution.sv
dv/sobel_x_3x3_convolution_test.sv
